### design/qsig_pkg.sv
// Shared types, constants and the threshold table for the q3.12 sigmoid/tanh block.
package qsig_pkg;

  // Tensor geometry limits.
  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned LIM_W   = $clog2(MAX_DIM + 2);
  localparam int unsigned IDX_W   = $clog2(MAX_DIM);

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FUNC_SEL      = 3'd0,
    CFG_ROW_WIDTH     = 3'd1,
    CFG_ROW_COUNT     = 3'd2,
    CFG_CHANNEL_COUNT = 3'd3,
    CFG_INPUT_PACKED  = 3'd4
  } cfg_index_e;

  // Data path widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned ACT_W    = 8;
  localparam logic [ACT_W-1:0] ACT_MAX = 8'd127;

  // Threshold table: one row of 128 thresholds per function.
  localparam int unsigned NUM_THR   = 128;
  localparam int unsigned THR_IDX_W = $clog2(NUM_THR);
  localparam int unsigned THR_W     = 16;
  localparam int unsigned U_W       = THR_IDX_W + 1;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified sample as it waits in the queue.
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             last;
    logic             fsel;
  } qsig_item_t;

  // One sample in flight through the binary search.
  typedef struct packed {
    qsig_item_t           item;
    logic [THR_IDX_W-1:0] u;
  } qsig_stage_t;

  // Fixed-point log format used only while the table is built.
  localparam int unsigned LOG_FRAC = 56;
  localparam logic [63:0] LN2_Q64  = 64'hB17217F7D1CF79AC;
  localparam int unsigned SH_SIG   = LOG_FRAC + 64 - 12;
  localparam int unsigned SH_TANH  = LOG_FRAC + 64 - 11;

  typedef logic [THR_W-1:0] thr_tab_t [2*NUM_THR];

  // log2(n) with LOG_FRAC fraction bits, by repeated squaring of the mantissa.
  function automatic logic [63:0] log2_fix(input logic [8:0] n);
    logic [63:0]  y;
    logic [127:0] sq;
    logic [63:0]  res;
    int unsigned  e;
    e = 0;
    for (int k = 0; k < 9; k++) begin
      if (n[k]) begin
        e = k;
      end
    end
    y   = 64'(n) << (62 - e);
    res = 64'(e) << LOG_FRAC;
    for (int i = 1; i <= LOG_FRAC; i++) begin
      sq = {64'd0, y} * {64'd0, y};
      y  = sq[125:62];
      if (y[63]) begin
        y = y >> 1;
        res[LOG_FRAC-i] = 1'b1;
      end
    end
    return res;
  endfunction

  // Threshold j is the ceiling of S*ln((255+2j)/(257-2j)); sigmoid rows first.
  function automatic thr_tab_t build_thr();
    thr_tab_t     tab;
    logic [63:0]  d;
    logic [127:0] p;
    for (int j = 1; j <= NUM_THR; j++) begin
      d = log2_fix(9'(255 + 2 * j)) - log2_fix(9'(257 - 2 * j));
      p = {64'd0, d} * {64'd0, LN2_Q64};
      tab[j-1] = THR_W'(p >> SH_SIG) + THR_W'(p[SH_SIG-1:0] != '0);
      tab[NUM_THR+j-1] = THR_W'(p >> SH_TANH) + THR_W'(p[SH_TANH-1:0] != '0);
    end
    return tab;
  endfunction

  localparam thr_tab_t THR_TAB = build_thr();

  // Table read: fsel picks the row, idx the threshold.
  function automatic logic [THR_W-1:0] thr_lookup(input logic fsel,
                                                  input logic [THR_IDX_W-1:0] idx);
    return THR_TAB[{fsel, idx}];
  endfunction

  // A dimension of zero acts as one; anything above the limit acts as the limit.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

### design/q312_sigmoid_tanh_to_int8.sv
// Top level: quantized sigmoid/tanh of a q3.12 sample stream to int8.
// Path: an accepted sample passes through the queue, the search stages and the output register.
// Throughput: one sample per cycle unless stalled; a padding word is taken but not output.
// The depth is set by the 7-step binary search over the 128-entry threshold table.
// Reset: sigmoid, 1 x 1 x 1 tensor, packed input, walk counters at zero, pipeline empty.
// The two-word queue lets input and output stall independently.
module q312_sigmoid_tanh_to_int8 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qsig_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [qsig_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [qsig_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [qsig_pkg::ACT_W-1:0]   activation_o,
  output logic                                last_of_tensor_o
);

  logic                 push, full, pop, empty;
  qsig_pkg::qsig_item_t push_item, head_item;

  // Classifying front end.
  qsig_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  // Queue between front and back.
  qsig_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty)
  );

  // Search pipeline and output register.
  qsig_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (head_item),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .activation_o     (activation_o),
    .last_of_tensor_o (last_of_tensor_o)
  );

endmodule

### design/qsig_fifo.sv
// Two-word queue that decouples the classifying front from the search pipeline.
module qsig_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  qsig_pkg::qsig_item_t item_i,
  output logic                full_o,
  input  logic                pop_i,
  output qsig_pkg::qsig_item_t item_o,
  output logic                empty_o
);

  qsig_pkg::qsig_item_t              mem_q [qsig_pkg::QUEUE_DEPTH];
  logic [qsig_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [qsig_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [qsig_pkg::QCNT_W-1:0]       count_q, count_d;

  assign full_o  = (count_q == qsig_pkg::QCNT_W'(qsig_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == qsig_pkg::QPTR_W'(qsig_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == qsig_pkg::QPTR_W'(qsig_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage for queued words.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i && full_o |-> pop_i)
    else $error("qsig_fifo: word written into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   push_i && !pop_i |=> !empty_o)
    else $error("qsig_fifo: queue empty right after a write");

endmodule

### design/qsig_front.sv
// Front end: configuration registers, tensor walk counters and sample classification.
module qsig_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qsig_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [qsig_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [qsig_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                full_i,
  output logic                                push_o,
  output qsig_pkg::qsig_item_t                item_o
);

  // Configuration registers.
  logic                       fsel_q;
  logic [qsig_pkg::CFG_W-1:0] row_width_q, row_count_q, chan_count_q;
  logic                       packed_q;

  // Tensor walk counters.
  logic [qsig_pkg::DIM_W-1:0] col_q, col_d;
  logic [qsig_pkg::IDX_W-1:0] row_q, row_d;
  logic [qsig_pkg::IDX_W-1:0] chan_q, chan_d;

  logic [qsig_pkg::DIM_W-1:0]    w, h, c;
  logic                          pad_en;
  logic [qsig_pkg::LIM_W-1:0]    limit;
  logic [qsig_pkg::DIM_W-1:0]    col_eff;
  logic [qsig_pkg::IDX_W-1:0]    row_eff, chan_eff;
  logic [qsig_pkg::LIM_W-1:0]    col_inc;
  logic [qsig_pkg::DIM_W-1:0]    row_inc, chan_inc;
  logic                          is_pad, end_of_row;
  logic                          in_accept;
  logic [qsig_pkg::MAG_W-1:0]    raw;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign in_accept   = in_valid_i && !full_i;

  // Effective geometry and counters brought back into range.
  always_comb begin
    w       = qsig_pkg::eff_dim(row_width_q);
    h       = qsig_pkg::eff_dim(row_count_q);
    c       = qsig_pkg::eff_dim(chan_count_q);
    pad_en  = !packed_q && w[0];
    limit   = qsig_pkg::LIM_W'(w) + qsig_pkg::LIM_W'(pad_en);
    col_eff  = (qsig_pkg::LIM_W'(col_q) >= limit) ? '0 : col_q;
    row_eff  = (qsig_pkg::DIM_W'(row_q) >= h) ? '0 : row_q;
    chan_eff = (qsig_pkg::DIM_W'(chan_q) >= c) ? '0 : chan_q;
    is_pad   = pad_en && (col_eff == w);
    col_inc  = qsig_pkg::LIM_W'(col_eff) + 1'b1;
    row_inc  = qsig_pkg::DIM_W'(row_eff) + 1'b1;
    chan_inc = qsig_pkg::DIM_W'(chan_eff) + 1'b1;
    end_of_row = is_pad || (col_inc >= limit);
  end

  // Next position in the walk.
  always_comb begin
    col_d  = col_inc[qsig_pkg::DIM_W-1:0];
    row_d  = row_eff;
    chan_d = chan_eff;
    if (end_of_row) begin
      col_d = '0;
      if (row_inc >= h) begin
        row_d  = '0;
        chan_d = (chan_inc >= c) ? '0 : chan_inc[qsig_pkg::IDX_W-1:0];
      end else begin
        row_d = row_inc[qsig_pkg::IDX_W-1:0];
      end
    end
  end

  // Classify the sample: sign, magnitude and end-of-tensor flag.
  always_comb begin
    raw         = sample_i;
    item_o.neg  = raw[qsig_pkg::SAMPLE_W-1];
    item_o.mag  = item_o.neg ? (qsig_pkg::MAG_W'(0) - raw) : raw;
    item_o.fsel = fsel_q;
    item_o.last = (col_eff == w - qsig_pkg::DIM_W'(1)) &&
                  (qsig_pkg::DIM_W'(row_eff) == h - qsig_pkg::DIM_W'(1)) &&
                  (qsig_pkg::DIM_W'(chan_eff) == c - qsig_pkg::DIM_W'(1));
  end

  assign push_o = in_accept && !is_pad;

  // Configuration writes; unknown indices are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsel_q       <= 1'b0;
      row_width_q  <= qsig_pkg::CFG_W'(1);
      row_count_q  <= qsig_pkg::CFG_W'(1);
      chan_count_q <= qsig_pkg::CFG_W'(1);
      packed_q     <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (qsig_pkg::cfg_index_e'(cfg_index_i))
        qsig_pkg::CFG_FUNC_SEL:      fsel_q       <= cfg_data_i[0];
        qsig_pkg::CFG_ROW_WIDTH:     row_width_q  <= cfg_data_i;
        qsig_pkg::CFG_ROW_COUNT:     row_count_q  <= cfg_data_i;
        qsig_pkg::CFG_CHANNEL_COUNT: chan_count_q <= cfg_data_i;
        qsig_pkg::CFG_INPUT_PACKED:  packed_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Counters advance on every accepted word, padding included.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      chan_q <= '0;
    end else if (in_accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      chan_q <= chan_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   push_o && item_o.last && !pad_en |=> col_q == '0 && row_q == '0 &&
                   chan_q == '0)
    else $error("qsig_front: walk did not restart after the last sample of the tensor");

endmodule

### design/qsig_back.sv
// Back end: pipelined binary search over the threshold table and the output register.
module qsig_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qsig_pkg::qsig_item_t                item_i,
  input  logic                                empty_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [qsig_pkg::ACT_W-1:0]   activation_o,
  output logic                                last_of_tensor_o
);

  localparam int unsigned STAGES = qsig_pkg::THR_IDX_W;

  logic [STAGES-1:0]      vld_q;
  qsig_pkg::qsig_stage_t  stg_q [STAGES];
  qsig_pkg::qsig_stage_t  nxt   [STAGES];
  logic                   out_vld_q;
  logic [qsig_pkg::ACT_W-1:0] act_q, act_d;
  logic                   last_q;
  logic                   en;
  logic                   top;
  logic [qsig_pkg::U_W-1:0] u_full;

  // The whole pipeline moves whenever the output register can take a word.
  assign en    = !out_vld_q || out_ready_i;
  assign pop_o = en && !empty_i;

  // One search step per stage: stage k tests the bit of weight 2^(STAGES-1-k).
  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      logic [qsig_pkg::THR_IDX_W-1:0] bitw;
      logic [qsig_pkg::THR_IDX_W-1:0] idx;
      bitw   = qsig_pkg::THR_IDX_W'(1) << (STAGES - 1 - k);
      idx    = stg_q[k].u | (bitw - qsig_pkg::THR_IDX_W'(1));
      nxt[k] = stg_q[k];
      if (qsig_pkg::thr_lookup(stg_q[k].item.fsel, idx) <= stg_q[k].item.mag) begin
        nxt[k].u = stg_q[k].u | bitw;
      end
    end
  end

  // Last threshold decides the full-scale count; then sign and saturation.
  always_comb begin
    top = qsig_pkg::thr_lookup(stg_q[STAGES-1].item.fsel, '1) <=
          stg_q[STAGES-1].item.mag;
    u_full = qsig_pkg::U_W'(nxt[STAGES-1].u) + qsig_pkg::U_W'(top);
    if (stg_q[STAGES-1].item.neg) begin
      act_d = qsig_pkg::ACT_W'(qsig_pkg::U_W'(0) - u_full);
    end else if (qsig_pkg::ACT_W'(u_full) > qsig_pkg::ACT_MAX) begin
      act_d = qsig_pkg::ACT_MAX;
    end else begin
      act_d = qsig_pkg::ACT_W'(u_full);
    end
  end

  // Valid bits of the stages and of the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[STAGES-2:0], !empty_i};
      out_vld_q <= vld_q[STAGES-1];
    end
  end

  // Stage and output payload.
  always_ff @(posedge clk_i) begin
    if (en) begin
      stg_q[0].item <= item_i;
      stg_q[0].u    <= '0;
      for (int k = 1; k < STAGES; k++) begin
        stg_q[k] <= nxt[k-1];
      end
      act_q  <= act_d;
      last_q <= stg_q[STAGES-1].item.last;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign activation_o     = act_q;
  assign last_of_tensor_o = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_vld_q && !out_ready_i |=> out_vld_q && $stable(vld_q))
    else $error("qsig_back: pipeline moved while the output was stalled");

endmodule
